// File: sv/upsc_pkg.sv
`timescale 1ns / 1ps

package upsc_pkg;

  // Input beat: one source pixel or one output request.
  typedef struct packed {
    logic       mode;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } upsc_in_t;

  // Output beat: one item of the enlarged image, or a status code.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic       image_end;
  } upsc_out_t;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_PAD     = 3'd1;
  localparam logic [2:0] KIND_NONE    = 3'd2;
  localparam logic [2:0] KIND_STORED  = 3'd3;
  localparam logic [2:0] KIND_REFUSED = 3'd4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd2;

  localparam logic [6:0] FACTOR_LIMIT = 7'd100;

  // Output queue: covers the beat in the read stage plus one draining beat.
  localparam int unsigned OUT_FIFO_DEPTH = 3;
  localparam int unsigned OUT_FIFO_CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int unsigned OUT_FIFO_PTR_W = $clog2(OUT_FIFO_DEPTH);

endpackage

// File: sv/upsc_ram.sv
`timescale 1ns / 1ps

module upsc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/upsc_out_fifo.sv
`timescale 1ns / 1ps

module upsc_out_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  upsc_pkg::upsc_out_t                push_data_i,
  input  logic                               pop_i,
  output logic                               valid_o,
  output upsc_pkg::upsc_out_t                head_o,
  output logic [upsc_pkg::OUT_FIFO_CNT_W-1:0] count_o
);

  import upsc_pkg::*;

  localparam logic [OUT_FIFO_PTR_W-1:0] LAST_PTR = OUT_FIFO_PTR_W'(OUT_FIFO_DEPTH - 1);

  upsc_out_t                 mem_q [OUT_FIFO_DEPTH];
  logic [OUT_FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                      do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + OUT_FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + OUT_FIFO_PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + OUT_FIFO_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - OUT_FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// File: sv/integer_pixel_upscaler.sv
`timescale 1ns / 1ps

// Nearest-neighbor integer upscaler for 24-bit RGB. Load beats (mode 0) fill a
// line buffer one pixel each; once a full source row is held, request beats
// (mode 1) pull the enlarged image one item at a time: each pixel repeated
// scale_factor times across, each row scale_factor times down, and each output
// row closed by (width*factor) mod 4 zero padding items. Every input beat yields
// exactly one output beat. The block takes one beat per clock while in_stall_o
// is low; a result passes from acceptance (control update and line buffer read)
// through the registered RAM read data of the read stage into the output queue.
// That rate comes from the line buffer having one write port for loads and one
// read port for emits, and from all row/repeat counters updating in the same
// cycle. A three-entry output queue keeps out_stall_i off any combinational path
// to in_stall_o; in_stall_o rises only when that queue cannot absorb what is
// already in flight. No clearing pass is needed after reset. Configuration
// writes are always accepted (cfg_ready_o is always high).
module integer_pixel_upscaler #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input item channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  upsc_pkg::upsc_in_t             in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output upsc_pkg::upsc_out_t            out_data_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [upsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import upsc_pkg::*;

  // Counter width holds MAX_WIDTH itself; compare width has one more bit.
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW     = CNT_W + 1;
  localparam int unsigned ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers
  logic [6:0]  scale_factor_q;
  logic [10:0] source_width_q;
  logic [15:0] source_height_q;

  // Row/repeat state
  logic [CNT_W-1:0] load_pos_q, load_pos_d;
  logic             row_ready_q, row_ready_d;
  logic [CNT_W-1:0] emit_col_q, emit_col_d;
  logic [6:0]       across_q, across_d;
  logic [6:0]       down_q, down_d;
  logic [1:0]       pad_cnt_q, pad_cnt_d;
  logic [15:0]      rows_q, rows_d;
  logic             pad_phase_q, pad_phase_d;

  // Read stage: one beat whose pixel (if any) is in the RAM read register
  logic       s1_valid_q;
  logic [2:0] s1_kind_q, s1_kind_d;
  logic       s1_row_end_q, s1_row_end_d;
  logic       s1_image_end_q, s1_image_end_d;

  // Effective configuration
  logic [6:0]    f_eff;
  logic [EW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [3:0]    pad_prod;
  logic [1:0]    pad;

  logic             accept;
  logic             finish;
  logic [EW-1:0]    pos_inc;
  logic [EW-1:0]    col_next;
  logic [7:0]       across_inc;
  logic [7:0]       down_inc;
  logic [2:0]       pad_inc;
  logic [16:0]      rows_inc;

  logic              ram_we, ram_re;
  logic [23:0]       ram_rdata;

  upsc_out_t                 push_data;
  logic                      fifo_valid;
  upsc_out_t                 fifo_head;
  logic [OUT_FIFO_CNT_W-1:0] fifo_cnt;
  logic [OUT_FIFO_CNT_W:0]   occupancy;

  // Out-of-range register values clamp into their legal ranges.
  always_comb begin
    if (scale_factor_q == '0) begin
      f_eff = 7'd1;
    end else if (scale_factor_q > FACTOR_LIMIT) begin
      f_eff = FACTOR_LIMIT;
    end else begin
      f_eff = scale_factor_q;
    end

    if (source_width_q == '0) begin
      w_eff = EW'(1);
    end else if (int'(source_width_q) > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(source_width_q);
    end

    h_eff = (source_height_q == '0) ? 16'd1 : source_height_q;

    // (w * f) mod 4 only needs the low two bits of each
    pad_prod = {2'b00, w_eff[1:0]} * {2'b00, f_eff[1:0]};
    pad      = pad_prod[1:0];
  end

  // in_stall_o looks at registered occupancy only
  assign occupancy  = {1'b0, fifo_cnt} + (OUT_FIFO_CNT_W + 1)'(s1_valid_q);
  assign in_stall_o = (occupancy >= (OUT_FIFO_CNT_W + 1)'(OUT_FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    load_pos_d     = load_pos_q;
    row_ready_d    = row_ready_q;
    emit_col_d     = emit_col_q;
    across_d       = across_q;
    down_d         = down_q;
    pad_cnt_d      = pad_cnt_q;
    rows_d         = rows_q;
    pad_phase_d    = pad_phase_q;
    s1_kind_d      = KIND_NONE;
    s1_row_end_d   = 1'b0;
    s1_image_end_d = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    finish         = 1'b0;
    pos_inc        = EW'(load_pos_q) + EW'(1);
    col_next       = EW'(emit_col_q);
    across_inc     = {1'b0, across_q} + 8'd1;
    down_inc       = {1'b0, down_q} + 8'd1;
    pad_inc        = {1'b0, pad_cnt_q} + 3'd1;
    rows_inc       = {1'b0, rows_q} + 17'd1;

    if (accept) begin
      if (in_data_i.mode == MODE_LOAD) begin
        if (row_ready_q) begin
          s1_kind_d = KIND_REFUSED;
        end else begin
          s1_kind_d = KIND_STORED;
          ram_we    = (load_pos_q < CNT_W'(MAX_WIDTH));
          if (pos_inc >= w_eff) begin
            load_pos_d  = '0;
            row_ready_d = 1'b1;
          end else begin
            load_pos_d = pos_inc[CNT_W-1:0];
          end
        end
      end else if (!row_ready_q) begin
        s1_kind_d = KIND_NONE;
      end else if (!pad_phase_q) begin
        s1_kind_d = KIND_PIXEL;
        ram_re    = 1'b1;
        if (across_inc >= {1'b0, f_eff}) begin
          across_d = '0;
          col_next = EW'(emit_col_q) + EW'(1);
        end else begin
          across_d = across_inc[6:0];
        end
        emit_col_d = col_next[CNT_W-1:0];
        if (col_next >= w_eff) begin
          if (pad == 2'd0) begin
            finish = 1'b1;
          end else begin
            pad_phase_d = 1'b1;
            pad_cnt_d   = '0;
          end
        end
      end else begin
        s1_kind_d = KIND_PAD;
        pad_cnt_d = pad_inc[1:0];
        if (pad_inc >= {1'b0, pad}) begin
          finish = 1'b1;
        end
      end
    end

    // Close the output row; the last repeat of the last source row ends the image.
    if (finish) begin
      s1_row_end_d = 1'b1;
      emit_col_d   = '0;
      across_d     = '0;
      pad_cnt_d    = '0;
      pad_phase_d  = 1'b0;
      if (down_inc >= {1'b0, f_eff}) begin
        down_d      = '0;
        row_ready_d = 1'b0;
        if (rows_inc >= {1'b0, h_eff}) begin
          rows_d         = '0;
          s1_image_end_d = 1'b1;
        end else begin
          rows_d = rows_inc[15:0];
        end
      end else begin
        down_d = down_inc[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_factor_q  <= 7'd1;
      source_width_q  <= 11'd1;
      source_height_q <= 16'd1;
      load_pos_q      <= '0;
      row_ready_q     <= 1'b0;
      emit_col_q      <= '0;
      across_q        <= '0;
      down_q          <= '0;
      pad_cnt_q       <= '0;
      rows_q          <= '0;
      pad_phase_q     <= 1'b0;
      s1_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SCALE_FACTOR:  scale_factor_q  <= cfg_data_i[6:0];
          CFG_SOURCE_WIDTH:  source_width_q  <= cfg_data_i[10:0];
          CFG_SOURCE_HEIGHT: source_height_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      load_pos_q  <= load_pos_d;
      row_ready_q <= row_ready_d;
      emit_col_q  <= emit_col_d;
      across_q    <= across_d;
      down_q      <= down_d;
      pad_cnt_q   <= pad_cnt_d;
      rows_q      <= rows_d;
      pad_phase_q <= pad_phase_d;
      s1_valid_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q      <= s1_kind_d;
      s1_row_end_q   <= s1_row_end_d;
      s1_image_end_q <= s1_image_end_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Line buffer. A load's write lands before any later emit's read, so no
  // forwarding is needed.
  upsc_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(load_pos_q[ADDR_W-1:0]),
    .wdata_i({in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in}),
    .re_i   (ram_re),
    .raddr_i(emit_col_q[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Read-stage beat joins the RAM data; color fields are zero unless a pixel.
  always_comb begin
    push_data.kind      = s1_kind_q;
    push_data.row_end   = s1_row_end_q;
    push_data.image_end = s1_image_end_q;
    if (s1_kind_q == KIND_PIXEL) begin
      push_data.red_out   = ram_rdata[23:16];
      push_data.green_out = ram_rdata[15:8];
      push_data.blue_out  = ram_rdata[7:0];
    end else begin
      push_data.red_out   = '0;
      push_data.green_out = '0;
      push_data.blue_out  = '0;
    end
  end

  upsc_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_valid_q),
    .push_data_i(push_data),
    .pop_i      (!out_stall_i),
    .valid_o    (fifo_valid),
    .head_o     (fifo_head),
    .count_o    (fifo_cnt)
  );

  assign out_valid_o = fifo_valid;
  assign out_data_o  = fifo_head;

  // Beats in flight never exceed the output queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= (OUT_FIFO_CNT_W + 1)'(OUT_FIFO_DEPTH))
    else $error("output queue overflow");

  // A pixel is only emitted from a ready row.
  a_pixel_from_ready_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q == KIND_PIXEL) |-> $past(row_ready_q))
    else $error("pixel emitted without a ready row");

  // A refused load leaves the load position alone.
  a_refused_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.mode == MODE_LOAD && row_ready_q) |=> $stable(load_pos_q))
    else $error("refused load moved the load position");

  // Image end closes a row and releases the line buffer with the row count cleared.
  a_image_end_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_image_end_q) |-> (s1_row_end_q && !row_ready_q && rows_q == '0))
    else $error("image end without row close");

endmodule
